FILE: hdl/gcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg: shared types for the Euclidean GCD engine
// Holds the field width, the controller state type and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gcd_pkg;

    // Width of the operand and result fields on the ports.
    localparam int unsigned FIELD_WIDTH = 32;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_EVAL
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the operands of an accepted request
        logic init;     // start a remainder with the current pair
        logic step;     // one bit of the restoring remainder
        logic swap;     // replace the pair with divisor and remainder, then init
        logic finish;   // capture the result
        logic zero;     // the result comes from a zero second operand
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic y_zero;   // current divisor is zero
        logic rem_zero; // last remainder is zero
        logic last;     // current step is the final bit of the remainder
    } t_status;

endpackage

FILE: hdl/gcd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_datapath: operand registers and bit-serial remainder unit
// Holds the working pair, a restoring remainder unit that retires one
// dividend bit per cycle, and the result registers.
// ----------------------------------------------------------------------------
module gcd_datapath #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic [gcd_pkg::FIELD_WIDTH-1:0]   i_first_operand,
    input  logic [gcd_pkg::FIELD_WIDTH-1:0]   i_second_operand,
    input  gcd_pkg::t_cmd                     i_cmd,
    output gcd_pkg::t_status                  o_status,
    output logic [gcd_pkg::FIELD_WIDTH-1:0]   o_divisor_result,
    output logic                              o_zero_operand
);

    localparam int unsigned FW = gcd_pkg::FIELD_WIDTH;
    localparam int unsigned CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
    localparam logic [CW-1:0] LAST_BIT = CW'(DATA_WIDTH - 1);

    logic [DATA_WIDTH-1:0] x_in;
    logic [DATA_WIDTH-1:0] y_in;
    logic [FW-1:0]         x_out;
    logic [FW-1:0]         y_out;

    logic [DATA_WIDTH-1:0] r_x;
    logic [DATA_WIDTH-1:0] r_y;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_shift;
    logic [CW-1:0]         r_cnt;
    logic [FW-1:0]         r_res;
    logic                  r_zero;

    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   trial_sub;
    logic [DATA_WIDTH-1:0] n_rem;

    // Fit the port fields to the datapath width and the datapath to the ports.
    generate
        if (DATA_WIDTH > FW) begin : g_wide
            assign x_in  = {{(DATA_WIDTH-FW){1'b0}}, i_first_operand};
            assign y_in  = {{(DATA_WIDTH-FW){1'b0}}, i_second_operand};
            assign x_out = r_x[FW-1:0];
            assign y_out = r_y[FW-1:0];
        end else if (DATA_WIDTH == FW) begin : g_equal
            assign x_in  = i_first_operand;
            assign y_in  = i_second_operand;
            assign x_out = r_x;
            assign y_out = r_y;
        end else begin : g_narrow
            assign x_in  = i_first_operand[DATA_WIDTH-1:0];
            assign y_in  = i_second_operand[DATA_WIDTH-1:0];
            assign x_out = {{(FW-DATA_WIDTH){1'b0}}, r_x};
            assign y_out = {{(FW-DATA_WIDTH){1'b0}}, r_y};
        end
    endgenerate

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    // The partial remainder stays below the divisor, so the top bit of the
    // difference is set exactly when the divisor does not fit.
    always_comb begin
        trial     = {r_rem, r_shift[DATA_WIDTH-1]};
        trial_sub = trial - {1'b0, r_y};
        if (!trial_sub[DATA_WIDTH]) begin
            n_rem = trial_sub[DATA_WIDTH-1:0];
        end else begin
            n_rem = trial[DATA_WIDTH-1:0];
        end
    end

    // Working pair and remainder unit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= x_in;
            r_y <= y_in;
        end else if (i_cmd.init) begin
            r_rem   <= '0;
            r_shift <= r_x;
            r_cnt   <= '0;
        end else if (i_cmd.step) begin
            r_rem   <= n_rem;
            r_shift <= {r_shift[DATA_WIDTH-2:0], 1'b0};
            r_cnt   <= r_cnt + CW'(1);
        end else if (i_cmd.swap) begin
            r_x     <= r_y;
            r_y     <= r_rem;
            r_rem   <= '0;
            r_shift <= r_y;
            r_cnt   <= '0;
        end
    end

    // Result capture: the first operand when the divisor was zero, else the divisor.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res  <= i_cmd.zero ? x_out : y_out;
            r_zero <= i_cmd.zero;
        end
    end

    assign o_status.y_zero   = (r_y == '0);
    assign o_status.rem_zero = (r_rem == '0);
    assign o_status.last     = (r_cnt == LAST_BIT);
    assign o_divisor_result  = r_res;
    assign o_zero_operand    = r_zero;

endmodule

FILE: hdl/gcd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_ctrl: sequencer for the Euclidean GCD engine
// Accepts requests, runs one remainder per Euclid step on the datapath and
// raises the done strobe for one cycle when the result is captured.
// ----------------------------------------------------------------------------
module gcd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  gcd_pkg::t_status i_status,
    output gcd_pkg::t_cmd    o_cmd,
    output logic             busy,
    output logic             o_done
);

    gcd_pkg::t_state r_state;
    gcd_pkg::t_state n_state;
    logic            r_done;

    // State register and done strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gcd_pkg::ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.finish;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            gcd_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = gcd_pkg::ST_CHECK;
                end
            end
            gcd_pkg::ST_CHECK: begin
                n_state = i_status.y_zero ? gcd_pkg::ST_IDLE : gcd_pkg::ST_DIV;
            end
            gcd_pkg::ST_DIV: begin
                if (i_status.last) begin
                    n_state = gcd_pkg::ST_EVAL;
                end
            end
            gcd_pkg::ST_EVAL: begin
                n_state = i_status.rem_zero ? gcd_pkg::ST_IDLE : gcd_pkg::ST_DIV;
            end
            default: begin
                n_state = gcd_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            gcd_pkg::ST_IDLE: begin
                o_cmd.load = start;
            end
            gcd_pkg::ST_CHECK: begin
                o_cmd.init   = ~i_status.y_zero;
                o_cmd.finish = i_status.y_zero;
                o_cmd.zero   = i_status.y_zero;
            end
            gcd_pkg::ST_DIV: begin
                o_cmd.step = 1'b1;
            end
            gcd_pkg::ST_EVAL: begin
                o_cmd.swap   = ~i_status.rem_zero;
                o_cmd.finish = i_status.rem_zero;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign busy   = (r_state != gcd_pkg::ST_IDLE);
    assign o_done = r_done;

endmodule

FILE: hdl/euclid_gcd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euclid_gcd: greatest common divisor by Euclid's remainder algorithm
// A zero second operand skips the division; otherwise k Euclid steps run, each
// a DATA_WIDTH-bit bit-serial remainder plus one check (at most 46 steps at 32
// bits). Requests are taken one at a time; busy drops with the one-cycle done
// strobe, which the receiver cannot stall, and the next request may be taken then.
// Synchronous active-low reset returns the sequencer to idle with no strobe.
// ----------------------------------------------------------------------------
module euclid_gcd #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [gcd_pkg::FIELD_WIDTH-1:0] i_first_operand,
    input  logic [gcd_pkg::FIELD_WIDTH-1:0] i_second_operand,
    output logic                            o_done,
    output logic [gcd_pkg::FIELD_WIDTH-1:0] o_divisor_result,
    output logic                            o_zero_operand
);

    gcd_pkg::t_cmd    cmd;
    gcd_pkg::t_status status;

    // Sequencer.
    gcd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_done   (o_done)
    );

    // Operand registers and remainder unit.
    gcd_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_divisor_result (o_divisor_result),
        .o_zero_operand   (o_zero_operand)
    );

    // The done strobe never lasts more than one cycle.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done strobe held for more than one cycle");

    // An accepted request keeps the engine busy and gives no immediate result.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("request accepted without the engine going busy");

    // A zero second operand finishes straight from the check, with the flag raised.
    a_zero_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_second_operand == '0)) |=> ##1 (o_done && o_zero_operand))
        else $error("zero second operand not reported two cycles after acceptance");

    // The done strobe only appears once the sequencer is idle again.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("done strobe raised while a request is still in flight");

endmodule

FILE: bench/euclid_gcd_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euclid_gcd_test: self-checking bench for the Euclidean GCD engine
// Sends operand pairs through the start/busy handshake and compares every
// done strobe with a behavioural GCD. It covers zero operands, the extremes of
// the fields and the longest remainder chains, then runs mixed random pairs;
// throughout, the sender pauses between random bursts of requests.
// ----------------------------------------------------------------------------
module euclid_gcd_test;

    localparam int unsigned W            = gcd_pkg::FIELD_WIDTH;
    localparam int unsigned RANDOM_COUNT = 372;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned CYCLE_LIMIT  = 4000000;
    localparam int unsigned REPORT_LIMIT = 10;

    // Random operand classes used by the random phase.
    typedef enum int unsigned {
        PAIR_ZERO_SECOND,
        PAIR_ZERO_FIRST,
        PAIR_COMMON_FACTOR,
        PAIR_EQUAL,
        PAIR_SMALL,
        PAIR_SHIFTED,
        PAIR_FULL
    } t_pair_kind;

    // One expected GCD result.
    typedef struct packed {
        logic [W-1:0] divisor;
        logic         zero;
    } t_gcd;

    logic         i_clk            = 1'b0;
    logic         i_rst_n          = 1'b0;
    logic         start            = 1'b0;
    logic [W-1:0] i_first_operand  = '0;
    logic [W-1:0] i_second_operand = '0;
    logic         busy;
    logic         o_done;
    logic [W-1:0] o_divisor_result;
    logic         o_zero_operand;

    t_gcd        pending_gcds[$];
    int unsigned requests_sent   = 0;
    int unsigned results_checked = 0;
    int unsigned zero_divisors   = 0;
    int unsigned error_count     = 0;
    int unsigned cycle_count     = 0;
    int unsigned burst_left      = 0;

    euclid_gcd DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .o_done           (o_done),
        .o_divisor_result (o_divisor_result),
        .o_zero_operand   (o_zero_operand)
    );

    // Clock: 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Behavioural GCD by repeated remainders; a zero divisor returns the
    // first operand with the flag set.
    function automatic t_gcd compute_gcd(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W-1:0] x;
        logic [W-1:0] y;
        logic [W-1:0] r;
        t_gcd         res;
        x = a;
        y = b;
        if (y == '0) begin
            res.divisor = x;
            res.zero    = 1'b1;
            return res;
        end
        r = x % y;
        while (r != '0) begin
            x = y;
            y = r;
            r = x % y;
        end
        res.divisor = y;
        res.zero    = 1'b0;
        return res;
    endfunction

    // Records one failure, printing only the first few in detail.
    task automatic note_error(input string what, input logic [W-1:0] exp_val,
                              input logic [W-1:0] act_val);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("[%0t] %s: expected %h, got %h", $realtime, what, exp_val, act_val);
        end
    endtask

    // Sender pacing: bursts of back-to-back requests separated by random gaps.
    // Some gaps start at acceptance, others only once the engine is idle again,
    // so that the next request lands on different phases of its work.
    task automatic pace_sender();
        int unsigned gap;
        int unsigned mode;
        if (burst_left != 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 7);
        mode = $urandom_range(0, 3);
        if (mode == 0) begin
            return;
        end
        gap = $urandom_range(1, 12);
        start <= 1'b0;
        if (mode == 1) begin
            @(posedge i_clk);
            while (busy !== 1'b0) @(posedge i_clk);
        end
        // The operands wander while start is low; the engine must ignore them.
        repeat (gap) begin
            i_first_operand  <= $urandom;
            i_second_operand <= $urandom;
            @(posedge i_clk);
        end
    endtask

    // Issues one request and holds it until the engine accepts it.
    task automatic send_request(input logic [W-1:0] a, input logic [W-1:0] b);
        pace_sender();
        start            <= 1'b1;
        i_first_operand  <= a;
        i_second_operand <= b;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pending_gcds.push_back(compute_gcd(a, b));
        requests_sent++;
        if (b == '0) begin
            zero_divisors++;
        end
    endtask

    // Result checker: every done strobe is matched with the oldest expectation.
    always @(posedge i_clk) begin
        t_gcd exp_res;
        if (i_rst_n === 1'b1 && o_done !== 1'b0) begin
            if (pending_gcds.size() == 0) begin
                note_error("result with no request outstanding", '0, o_divisor_result);
            end else begin
                exp_res = pending_gcds.pop_front();
                results_checked++;
                if (o_divisor_result !== exp_res.divisor) begin
                    note_error("divisor_result", exp_res.divisor, o_divisor_result);
                end
                if (o_zero_operand !== exp_res.zero) begin
                    note_error("zero_operand", W'(exp_res.zero), W'(o_zero_operand));
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_gcds.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // A zero second operand bypasses the division, whatever the first holds.
    task automatic test_zero_second_operand();
        send_request(32'h0000_0000, 32'h0000_0000);
        send_request(32'hFFFF_FFFF, 32'h0000_0000);
        send_request(32'h1357_9BDF, 32'h0000_0000);
        send_request(32'h0000_0001, 32'h0000_0000);
    endtask

    // A zero first operand gives the second operand after one remainder.
    task automatic test_zero_first_operand();
        send_request(32'h0000_0000, 32'h0000_0007);
        send_request(32'h0000_0000, 32'hFFFF_FFFF);
        send_request(32'h0000_0000, 32'h0000_0001);
    endtask

    // Field extremes, ordering of the operands and simple common factors.
    task automatic test_field_extremes();
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'h0000_0001, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'h0000_0001);
        send_request(32'h8000_0000, 32'h4000_0000);
        send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_request(32'hAAAA_AAAA, 32'h5555_5555);
        send_request(32'd48, 32'd18);
        send_request(32'd18, 32'd48);
    endtask

    // Consecutive Fibonacci numbers give the longest remainder chain; two large close operands follow.
    task automatic test_longest_chain();
        send_request(32'd2971215073, 32'd1836311903);
        send_request(32'd1836311903, 32'd2971215073);
        send_request(32'd4294967291, 32'd4294967279);
    endtask

    // Mixed random pairs: full-width pairs most often, else one of the special classes.
    task automatic test_random_pairs(input int unsigned count);
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [W-1:0] g;
        t_pair_kind   kind;
        repeat (count) begin
            kind = t_pair_kind'($urandom_range(0, 9) > 6 ? PAIR_FULL
                                                          : $urandom_range(0, 5));
            case (kind)
                PAIR_ZERO_SECOND: begin
                    a = $urandom;
                    b = '0;
                end
                PAIR_ZERO_FIRST: begin
                    a = '0;
                    b = $urandom;
                end
                PAIR_COMMON_FACTOR: begin
                    g = $urandom_range(1, 65535);
                    a = g * W'($urandom_range(1, 65535));
                    b = g * W'($urandom_range(1, 65535));
                end
                PAIR_EQUAL: begin
                    a = $urandom;
                    b = a;
                end
                PAIR_SMALL: begin
                    a = $urandom_range(0, 255);
                    b = $urandom_range(0, 255);
                end
                PAIR_SHIFTED: begin
                    a = $urandom << $urandom_range(0, 31);
                    b = $urandom << $urandom_range(0, 31);
                end
                default: begin
                    a = $urandom;
                    b = $urandom;
                end
            endcase
            send_request(a, b);
        end
    endtask

    // Test sequence.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_second_operand();
        test_zero_first_operand();
        test_field_extremes();
        test_longest_chain();
        test_random_pairs(RANDOM_COUNT);

        // Drain the outstanding results, then watch for stray strobes.
        start <= 1'b0;
        while (pending_gcds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_gcds.size() != 0) begin
            note_error("results never delivered", '0, W'(pending_gcds.size()));
        end

        $display("Sent %0d requests (%0d with a zero second operand), checked %0d results.",
                 requests_sent, zero_divisors, results_checked);
        $display("Run took %0d cycles with %0d failures.", cycle_count, error_count);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
